FILE: hdl/tbt_pkg.sv
// Package for the threshold boundary tracer.
// Holds the transaction, configuration and memory request types, codes,
// sizes and the vertex helper functions. No dependencies.
package tbt_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int STRIDE     = MAX_COLS + 1;
  localparam int NVERT      = (MAX_ROWS + 1) * STRIDE;
  localparam int ADDR_W     = $clog2(NVERT);
  localparam int ROW_W      = $clog2(MAX_ROWS + 2);
  localparam int COL_W      = $clog2(MAX_COLS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [3:0] DIR_UP    = 4'b0001;
  localparam logic [3:0] DIR_LEFT  = 4'b0010;
  localparam logic [3:0] DIR_RIGHT = 4'b0100;
  localparam logic [3:0] DIR_DOWN  = 4'b1000;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_FETCH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_VERTEX   = 2'd0,
    ST_DONE     = 2'd1,
    ST_CONFLICT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER  = 3'd0,
    CFG_UPPER  = 3'd1,
    CFG_ROWS   = 3'd2,
    CFG_COLS   = 3'd3,
    CFG_MERGE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_FETCH,
    S_CHK,
    S_SCAN,
    S_STEP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         pixel_row;
    logic [5:0]         pixel_col;
    logic signed [15:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] vertex_row;
    logic [6:0] vertex_col;
    logic       last_of_contour;
  } out_t;

  typedef struct packed {
    logic signed [15:0] lower_threshold;
    logic signed [15:0] upper_threshold;
    logic [6:0]         row_count;
    logic [6:0]         column_count;
    logic               merge_adjacent;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } vtx_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [3:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] vtx_addr(input vtx_t v);
    return ADDR_W'(int'(v.row) * STRIDE + int'(v.col));
  endfunction

  function automatic vtx_t vtx_inc(input vtx_t v);
    vtx_t r;
    r = v;
    if (v.col == COL_W'(MAX_COLS)) begin
      r.col = '0;
      r.row = v.row + ROW_W'(1);
    end else begin
      r.col = v.col + COL_W'(1);
    end
    return r;
  endfunction

  // Corners: 0 lower left, 1 lower right, 2 upper right, 3 upper left.
  function automatic logic [3:0][3:0] merge_edges(input logic [3:0][3:0] n, input logic m);
    logic [3:0][3:0] r;
    r = n;
    if (m && ((r[1] & DIR_LEFT) != 4'd0)) r[1] = r[1] & ~DIR_LEFT;
    else r[0] = r[0] | DIR_RIGHT;
    if (m && ((r[2] & DIR_DOWN) != 4'd0)) r[2] = r[2] & ~DIR_DOWN;
    else r[1] = r[1] | DIR_UP;
    if (m && ((r[3] & DIR_RIGHT) != 4'd0)) r[3] = r[3] & ~DIR_RIGHT;
    else r[2] = r[2] | DIR_LEFT;
    if (m && ((r[0] & DIR_UP) != 4'd0)) r[0] = r[0] & ~DIR_UP;
    else r[3] = r[3] | DIR_DOWN;
    return r;
  endfunction

endpackage

FILE: hdl/tbt_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module tbt_ram #(
  parameter int Width = 4,
  parameter int Depth = 4225
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tbt_cfg.sv
// Configuration registers of the threshold boundary tracer.
// Depends on tbt_pkg.
module tbt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tbt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tbt_pkg::cfg_t                  cfg_o
);

  tbt_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tbt_pkg::CFG_LOWER: cfg_d.lower_threshold = cfg_data_i;
        tbt_pkg::CFG_UPPER: cfg_d.upper_threshold = cfg_data_i;
        tbt_pkg::CFG_ROWS:  cfg_d.row_count       = cfg_data_i[6:0];
        tbt_pkg::CFG_COLS:  cfg_d.column_count    = cfg_data_i[6:0];
        tbt_pkg::CFG_MERGE: cfg_d.merge_adjacent  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower_threshold <= 16'sh8000;
      cfg_q.upper_threshold <= 16'sh7fff;
      cfg_q.row_count       <= 7'd64;
      cfg_q.column_count    <= 7'd64;
      cfg_q.merge_adjacent  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/tbt_seq.sv
// Sequencer of the threshold boundary tracer: clear sweep, pixel load,
// vertex scan and trace step over the edge memory, and the result register.
// Depends on tbt_pkg.
module tbt_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbt_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tbt_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tbt_pkg::out_t     out_data_o,
  output tbt_pkg::mem_req_t mem_req_o,
  input  logic [3:0]        mem_rdata_i
);

  tbt_pkg::state_e state_q, state_d;

  logic [tbt_pkg::ADDR_W-1:0] clr_q, clr_d;
  logic [2:0]                 cnt_q, cnt_d;
  tbt_pkg::vtx_t [3:0]        corner_q, corner_d;
  logic [3:0][3:0]            nib_q, nib_d;
  logic [3:0]                 e_q, e_d;
  tbt_pkg::vtx_t              scan_q, scan_d;
  tbt_pkg::vtx_t              start_q, start_d;
  tbt_pkg::vtx_t              cur_q, cur_d;
  tbt_pkg::vtx_t              probe_q, probe_d;
  tbt_pkg::vtx_t              lat_q, lat_d;
  logic                       in_loop_q, in_loop_d;
  logic                       lat_v_q, lat_v_d;
  tbt_pkg::out_t              res_q, res_d;
  tbt_pkg::out_t              out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic            accept;
  logic            conflict;
  logic            pix_in;
  logic            slot_free;
  logic            probe_end;
  logic            hit;
  logic [1:0]      rd_idx;
  logic [3:0][3:0] merged;
  logic [3:0]      e_new;
  tbt_pkg::vtx_t   nxt;
  logic            last;
  logic [tbt_pkg::ROW_W-1:0] pr;
  logic [tbt_pkg::COL_W-1:0] pc;

  assign in_ready_o = (state_q == tbt_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign conflict   = $signed(cfg_i.lower_threshold) > $signed(cfg_i.upper_threshold);
  assign pix_in     = ($signed(in_data_i.pixel_value) >= $signed(cfg_i.lower_threshold))
                   && ($signed(in_data_i.pixel_value) <= $signed(cfg_i.upper_threshold))
                   && ({1'b0, in_data_i.pixel_row} < cfg_i.row_count)
                   && ({1'b0, in_data_i.pixel_col} < cfg_i.column_count)
                   && (32'(in_data_i.pixel_row) < tbt_pkg::MAX_ROWS)
                   && (32'(in_data_i.pixel_col) < tbt_pkg::MAX_COLS);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign probe_end  = (probe_q.row == tbt_pkg::ROW_W'(tbt_pkg::MAX_ROWS + 1));
  assign hit        = lat_v_q && (mem_rdata_i != 4'd0);
  assign rd_idx     = 2'(cnt_q - 3'd1);
  assign merged     = tbt_pkg::merge_edges(nib_q, cfg_i.merge_adjacent);
  assign pr         = tbt_pkg::ROW_W'(in_data_i.pixel_row);
  assign pc         = tbt_pkg::COL_W'(in_data_i.pixel_col);

  always_comb begin
    nxt   = cur_q;
    e_new = e_q;
    if ((e_q & tbt_pkg::DIR_UP) != 4'd0) begin
      e_new   = e_q & ~tbt_pkg::DIR_UP;
      nxt.row = cur_q.row - tbt_pkg::ROW_W'(1);
    end else if ((e_q & tbt_pkg::DIR_LEFT) != 4'd0) begin
      e_new   = e_q & ~tbt_pkg::DIR_LEFT;
      nxt.col = cur_q.col - tbt_pkg::COL_W'(1);
    end else if ((e_q & tbt_pkg::DIR_RIGHT) != 4'd0) begin
      e_new   = e_q & ~tbt_pkg::DIR_RIGHT;
      nxt.col = cur_q.col + tbt_pkg::COL_W'(1);
    end else begin
      e_new   = e_q & ~tbt_pkg::DIR_DOWN;
      nxt.row = cur_q.row + tbt_pkg::ROW_W'(1);
    end
    last = (nxt == start_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tbt_pkg::S_CLEAR: begin
        if (clr_q == tbt_pkg::ADDR_W'(tbt_pkg::NVERT - 1)) state_d = tbt_pkg::S_IDLE;
      end
      tbt_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data_i.kind)
            tbt_pkg::KIND_CLEAR: state_d = tbt_pkg::S_CLEAR;
            tbt_pkg::KIND_LOAD:  if (pix_in) state_d = tbt_pkg::S_LD_RD;
            tbt_pkg::KIND_FETCH: state_d = tbt_pkg::S_FETCH;
            default: ;
          endcase
        end
      end
      tbt_pkg::S_LD_RD: begin
        if (cnt_q == 3'd4) state_d = tbt_pkg::S_LD_WR;
      end
      tbt_pkg::S_LD_WR: begin
        if (cnt_q == 3'd3) state_d = tbt_pkg::S_IDLE;
      end
      tbt_pkg::S_FETCH: begin
        if (conflict) state_d = tbt_pkg::S_EMIT;
        else if (in_loop_q) state_d = tbt_pkg::S_CHK;
        else state_d = tbt_pkg::S_SCAN;
      end
      tbt_pkg::S_CHK: begin
        if (mem_rdata_i == 4'd0) state_d = tbt_pkg::S_SCAN;
        else state_d = tbt_pkg::S_STEP;
      end
      tbt_pkg::S_SCAN: begin
        if (hit) state_d = tbt_pkg::S_STEP;
        else if (probe_end) state_d = tbt_pkg::S_EMIT;
      end
      tbt_pkg::S_STEP: state_d = tbt_pkg::S_EMIT;
      tbt_pkg::S_EMIT: begin
        if (slot_free) state_d = tbt_pkg::S_IDLE;
      end
      default: state_d = tbt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    corner_d    = corner_q;
    nib_d       = nib_q;
    e_d         = e_q;
    scan_d      = scan_q;
    start_d     = start_q;
    cur_d       = cur_q;
    probe_d     = probe_q;
    lat_d       = lat_q;
    in_loop_d   = in_loop_q;
    lat_v_d     = lat_v_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_req_o   = '0;
    case (state_q)
      tbt_pkg::S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        mem_req_o.wdata = 4'd0;
        clr_d           = clr_q + tbt_pkg::ADDR_W'(1);
      end
      tbt_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data_i.kind)
            tbt_pkg::KIND_CLEAR: begin
              clr_d     = '0;
              scan_d    = '0;
              start_d   = '0;
              cur_d     = '0;
              in_loop_d = 1'b0;
            end
            tbt_pkg::KIND_LOAD: begin
              cnt_d           = 3'd0;
              corner_d[0].row = pr + tbt_pkg::ROW_W'(1);
              corner_d[0].col = pc;
              corner_d[1].row = pr + tbt_pkg::ROW_W'(1);
              corner_d[1].col = pc + tbt_pkg::COL_W'(1);
              corner_d[2].row = pr;
              corner_d[2].col = pc + tbt_pkg::COL_W'(1);
              corner_d[3].row = pr;
              corner_d[3].col = pc;
              if (pix_in) scan_d = '0;
            end
            default: ;
          endcase
        end
      end
      tbt_pkg::S_LD_RD: begin
        if (cnt_q != 3'd4) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = tbt_pkg::vtx_addr(corner_q[cnt_q[1:0]]);
        end
        if (cnt_q != 3'd0) nib_d[rd_idx] = mem_rdata_i;
        cnt_d = (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
      end
      tbt_pkg::S_LD_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = tbt_pkg::vtx_addr(corner_q[cnt_q[1:0]]);
        mem_req_o.wdata = merged[cnt_q[1:0]];
        cnt_d           = cnt_q + 3'd1;
      end
      tbt_pkg::S_FETCH: begin
        if (conflict) begin
          res_d        = '0;
          res_d.status = tbt_pkg::ST_CONFLICT;
        end else if (in_loop_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = tbt_pkg::vtx_addr(cur_q);
        end else begin
          probe_d = scan_q;
          lat_v_d = 1'b0;
        end
      end
      tbt_pkg::S_CHK: begin
        if (mem_rdata_i == 4'd0) begin
          in_loop_d = 1'b0;
          probe_d   = scan_q;
          lat_v_d   = 1'b0;
        end else begin
          e_d = mem_rdata_i;
        end
      end
      tbt_pkg::S_SCAN: begin
        if (hit) begin
          scan_d    = lat_q;
          start_d   = lat_q;
          cur_d     = lat_q;
          in_loop_d = 1'b1;
          e_d       = mem_rdata_i;
        end else if (probe_end) begin
          scan_d       = probe_q;
          res_d        = '0;
          res_d.status = tbt_pkg::ST_DONE;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = tbt_pkg::vtx_addr(probe_q);
          lat_d           = probe_q;
          lat_v_d         = 1'b1;
          probe_d         = tbt_pkg::vtx_inc(probe_q);
        end
      end
      tbt_pkg::S_STEP: begin
        mem_req_o.we          = 1'b1;
        mem_req_o.waddr       = tbt_pkg::vtx_addr(cur_q);
        mem_req_o.wdata       = e_new;
        cur_d                 = nxt;
        res_d.status          = tbt_pkg::ST_VERTEX;
        res_d.vertex_row      = 7'(nxt.row);
        res_d.vertex_col      = 7'(nxt.col);
        res_d.last_of_contour = last;
        if (last) in_loop_d = 1'b0;
      end
      tbt_pkg::S_EMIT: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbt_pkg::S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      scan_q      <= '0;
      start_q     <= '0;
      cur_q       <= '0;
      in_loop_q   <= 1'b0;
      lat_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      start_q     <= start_d;
      cur_q       <= cur_d;
      in_loop_q   <= in_loop_d;
      lat_v_q     <= lat_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    corner_q <= corner_d;
    nib_q    <= nib_d;
    e_q      <= e_d;
    probe_q  <= probe_d;
    lat_q    <= lat_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/threshold_boundary_tracer.sv
// Threshold boundary tracer: a fetch answers conflict while lower threshold exceeds upper.
// Otherwise a fetch inside a loop steps along the contour; one outside a loop, or after a dead
// end, scans for a start vertex and answers done when none is left. One transaction in flight.
// After reset the edge memory is swept to zero with input ready low;
// configuration writes are taken during the sweep as well.
// Depends on tbt_pkg, tbt_cfg, tbt_seq and tbt_ram.
module threshold_boundary_tracer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tbt_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tbt_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tbt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tbt_pkg::cfg_t     cfg;
  tbt_pkg::mem_req_t mem_req;
  logic [3:0]        mem_rdata;

  tbt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tbt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  tbt_ram #(
    .Width (4),
    .Depth (tbt_pkg::NVERT)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
